// ----- design/spi_pkg.sv -----
package spi_pkg;

  localparam int MAX_SEGMENTS = 64;
  localparam int ADDR_W = (MAX_SEGMENTS > 1) ? $clog2(MAX_SEGMENTS) : 1;
  localparam int CNT_W = $clog2(MAX_SEGMENTS + 1);

  localparam int RAD_W = 66;
  localparam int ROOT_W = 33;
  localparam int DVD_W = 66;
  localparam int DVS_W = 32;

  localparam logic CMD_ADD = 1'b0;
  localparam logic CMD_QUERY = 1'b1;

  typedef enum logic [1:0] {
    ST_OK   = 2'd0,
    ST_FULL = 2'd1,
    ST_ZERO = 2'd2,
    ST_OVF  = 2'd3
  } status_t;

  typedef struct packed {
    logic signed [31:0] start_x;
    logic signed [31:0] start_y;
    logic signed [31:0] end_x;
    logic signed [31:0] end_y;
    logic [31:0]        speed;
    logic [31:0]        begin_time;
    logic [31:0]        finish_time;
  } seg_t;

  localparam int SEG_W = $bits(seg_t);

  // magnitude of b - a
  function automatic logic [32:0] mag33(input logic signed [31:0] a,
                                        input logic signed [31:0] b);
    logic signed [32:0] d;
    d = 33'(b) - 33'(a);
    return d[32] ? 33'(-d) : 33'(d);
  endfunction

endpackage

// ----- design/spi_ram.sv -----
module spi_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 64
) (
  input  logic                                           clk,
  input  logic                                           we,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0]   waddr,
  input  logic [WIDTH-1:0]                               wdata,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0]   raddr,
  output logic [WIDTH-1:0]                               rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

// ----- design/spi_sqrt.sv -----
module spi_sqrt (
  input  logic                       clk,
  input  logic                       rst,
  input  logic                       start,
  input  logic [spi_pkg::RAD_W-1:0]  radicand,
  output logic                       done,
  output logic [spi_pkg::ROOT_W-1:0] root
);
  import spi_pkg::*;

  localparam int REM_W = ROOT_W + 4;
  localparam int CW = $clog2(ROOT_W + 1);

  logic [RAD_W-1:0] rad;
  logic [REM_W-1:0] rem;
  logic [CW-1:0]    cnt;
  logic             busy;
  logic [REM_W-1:0] rem_sh;
  logic [REM_W-1:0] trial;
  logic [REM_W-1:0] rem_next;
  logic [ROOT_W-1:0] root_next;

  always_comb begin
    rem_sh = {rem[REM_W-3:0], rad[RAD_W-1:RAD_W-2]};
    trial = REM_W'({root, 2'b01});
    if (rem_sh >= trial) begin
      rem_next = rem_sh - trial;
      root_next = {root[ROOT_W-2:0], 1'b1};
    end else begin
      rem_next = rem_sh;
      root_next = {root[ROOT_W-2:0], 1'b0};
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt <= '0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy <= 1'b1;
        cnt <= CW'(ROOT_W);
        rem <= '0;
        root <= '0;
        rad <= radicand;
      end else if (busy) begin
        rad <= {rad[RAD_W-3:0], 2'b00};
        rem <= rem_next;
        root <= root_next;
        cnt <= cnt - 1'b1;
        if (cnt == CW'(1)) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

endmodule

// ----- design/spi_div.sv -----
module spi_div (
  input  logic                      clk,
  input  logic                      rst,
  input  logic                      start,
  input  logic [spi_pkg::DVD_W-1:0] dividend,
  input  logic [spi_pkg::DVS_W-1:0] divisor,
  output logic                      done,
  output logic [spi_pkg::DVD_W-1:0] quotient
);
  import spi_pkg::*;

  localparam int CW = $clog2(DVD_W + 1);

  logic [DVS_W:0]   rem;
  logic [DVS_W-1:0] dvs;
  logic [CW-1:0]    cnt;
  logic             busy;
  logic [DVS_W:0]   rem_sh;
  logic             ge;

  always_comb begin
    rem_sh = {rem[DVS_W-1:0], quotient[DVD_W-1]};
    ge = rem_sh >= {1'b0, dvs};
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt <= '0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy <= 1'b1;
        cnt <= CW'(DVD_W);
        rem <= '0;
        dvs <= divisor;
        quotient <= dividend;
      end else if (busy) begin
        rem <= ge ? (rem_sh - {1'b0, dvs}) : rem_sh;
        quotient <= {quotient[DVD_W-2:0], ge};
        cnt <= cnt - 1'b1;
        if (cnt == CW'(1)) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

endmodule

// ----- design/scan_path_position_interpolator_unit.sv -----
// add: multiply, sum, square root and divider from accept to result, each unit started
//   by a registered start pulse; the divider is skipped when the speed or length is zero
// query: an empty table goes straight to the result, else segments are read and checked
//   in turn, with two divisions after the search when the laser is on
// one word at a time: the next word is accepted the cycle after the result is registered
// reset clears the segment count but not the table memory
module scan_path_position_interpolator_unit (
  input  logic               clk,
  input  logic               rst,
  input  logic               in_valid,
  output logic               in_ready,
  input  logic               command,
  input  logic [31:0]        off_gap,
  input  logic signed [31:0] start_x,
  input  logic signed [31:0] start_y,
  input  logic signed [31:0] end_x,
  input  logic signed [31:0] end_y,
  input  logic [31:0]        scan_speed,
  input  logic [31:0]        query_time,
  output logic               out_valid,
  input  logic               out_ready,
  output logic               laser_on,
  output logic               speed_valid,
  output logic signed [31:0] pos_x,
  output logic signed [31:0] pos_y,
  output logic [31:0]        speed_out,
  output logic [1:0]         status
);
  import spi_pkg::*;

  typedef enum logic [3:0] {
    S_IDLE, S_A_MUL, S_A_SUM, S_A_SQRT, S_A_DIV, S_A_FIN,
    S_Q_RD, S_Q_CHK, S_Q_HIT, S_Q_MUL, S_Q_SX, S_Q_DX, S_Q_DY, S_OUT
  } state_t;

  state_t state;

  logic [CNT_W-1:0]  count;
  logic [31:0]       last_finish;
  logic [ADDR_W-1:0] idx;

  logic [31:0]        gap;
  logic signed [31:0] sx, sy, ex, ey;
  logic [31:0]        spd;
  logic [31:0]        qt;

  logic [32:0]       ux, uy;
  logic [65:0]       sq_a, sq_b;
  logic [RAD_W-1:0]  rad;
  logic [ROOT_W-1:0] len;
  logic [ROOT_W-1:0] dur;

  seg_t        hit;
  logic [32:0] mx, my;
  logic        neg_x, neg_y;
  logic [31:0] num, den;
  logic [64:0] prod_x, prod_y;

  logic              sq_start, sq_done;
  logic [ROOT_W-1:0] sq_root;
  logic              div_start, div_done;
  logic [DVD_W-1:0]  div_dvd, div_q;
  logic [DVS_W-1:0]  div_dvs;

  logic               r_laser, r_spdv;
  logic signed [31:0] r_px, r_py;
  logic [31:0]        r_spd;
  status_t            r_status;

  logic              mem_we;
  seg_t              mem_wdata, mem_rdata;
  logic [SEG_W-1:0]  rdata_raw;

  logic [32:0] a_begin;
  logic [33:0] a_finish;
  status_t     a_status;

  assign in_ready = (state == S_IDLE);
  assign mem_rdata = seg_t'(rdata_raw);

  always_comb begin
    a_begin = {1'b0, (count == '0) ? 32'd0 : last_finish} + {1'b0, gap};
    a_finish = {1'b0, a_begin} + 34'(dur);
    if (count == CNT_W'(MAX_SEGMENTS)) begin
      a_status = ST_FULL;
    end else if (spd == '0 || len == '0 || dur == '0) begin
      a_status = ST_ZERO;
    end else if (a_finish[33:32] != 2'b00) begin
      a_status = ST_OVF;
    end else begin
      a_status = ST_OK;
    end
    mem_we = (state == S_A_FIN) && (a_status == ST_OK);
    mem_wdata.start_x = sx;
    mem_wdata.start_y = sy;
    mem_wdata.end_x = ex;
    mem_wdata.end_y = ey;
    mem_wdata.speed = spd;
    mem_wdata.begin_time = a_begin[31:0];
    mem_wdata.finish_time = a_finish[31:0];
  end

  spi_ram #(.WIDTH(SEG_W), .DEPTH(MAX_SEGMENTS)) u_table (
    .clk   (clk),
    .we    (mem_we),
    .waddr (count[ADDR_W-1:0]),
    .wdata (mem_wdata),
    .raddr (idx),
    .rdata (rdata_raw)
  );

  spi_sqrt u_sqrt (
    .clk      (clk),
    .rst      (rst),
    .start    (sq_start),
    .radicand (rad),
    .done     (sq_done),
    .root     (sq_root)
  );

  spi_div u_div (
    .clk      (clk),
    .rst      (rst),
    .start    (div_start),
    .dividend (div_dvd),
    .divisor  (div_dvs),
    .done     (div_done),
    .quotient (div_q)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      count <= '0;
      out_valid <= 1'b0;
      sq_start <= 1'b0;
      div_start <= 1'b0;
      idx <= '0;
    end else begin
      sq_start <= (state == S_A_SUM);
      div_start <= ((state == S_A_SQRT) && sq_done && spd != '0 && sq_root != '0) ||
                   (state == S_Q_SX) || ((state == S_Q_DX) && div_done);
      if (out_valid && out_ready && state != S_OUT) begin
        out_valid <= 1'b0;
      end
      unique case (state)
        S_IDLE: begin
          if (in_valid) begin
            gap <= off_gap;
            sx <= start_x;
            sy <= start_y;
            ex <= end_x;
            ey <= end_y;
            spd <= scan_speed;
            qt <= query_time;
            ux <= mag33(start_x, end_x);
            uy <= mag33(start_y, end_y);
            r_laser <= 1'b0;
            r_spdv <= 1'b0;
            r_px <= '0;
            r_py <= '0;
            r_spd <= '0;
            r_status <= ST_OK;
            idx <= '0;
            if (command == CMD_ADD) begin
              state <= S_A_MUL;
            end else if (count == '0) begin
              state <= S_OUT;
            end else begin
              state <= S_Q_RD;
            end
          end
        end
        S_A_MUL: begin
          sq_a <= ux * ux;
          sq_b <= uy * uy;
          state <= S_A_SUM;
        end
        S_A_SUM: begin
          rad <= sq_a + sq_b;
          state <= S_A_SQRT;
        end
        S_A_SQRT: begin
          if (sq_done) begin
            len <= sq_root;
            if (spd == '0 || sq_root == '0) begin
              dur <= '0;
              state <= S_A_FIN;
            end else begin
              div_dvd <= DVD_W'(sq_root);
              div_dvs <= spd;
              state <= S_A_DIV;
            end
          end
        end
        S_A_DIV: begin
          if (div_done) begin
            dur <= div_q[ROOT_W-1:0];
            state <= S_A_FIN;
          end
        end
        S_A_FIN: begin
          r_status <= a_status;
          if (a_status == ST_OK) begin
            count <= count + 1'b1;
            last_finish <= a_finish[31:0];
          end
          state <= S_OUT;
        end
        S_Q_RD: begin
          state <= S_Q_CHK;
        end
        S_Q_CHK: begin
          if (qt <= mem_rdata.finish_time) begin
            hit <= mem_rdata;
            state <= S_Q_HIT;
          end else if (CNT_W'(idx) + 1'b1 == count) begin
            state <= S_OUT;
          end else begin
            idx <= idx + 1'b1;
            state <= S_Q_RD;
          end
        end
        S_Q_HIT: begin
          if (qt >= hit.begin_time && qt <= last_finish) begin
            r_spdv <= 1'b1;
            r_spd <= hit.speed;
          end
          mx <= mag33(hit.start_x, hit.end_x);
          my <= mag33(hit.start_y, hit.end_y);
          neg_x <= hit.end_x < hit.start_x;
          neg_y <= hit.end_y < hit.start_y;
          num <= qt - hit.begin_time;
          den <= hit.finish_time - hit.begin_time;
          if (qt >= hit.begin_time && qt < last_finish) begin
            state <= S_Q_MUL;
          end else begin
            state <= S_OUT;
          end
        end
        S_Q_MUL: begin
          prod_x <= mx * num;
          prod_y <= my * num;
          state <= S_Q_SX;
        end
        S_Q_SX: begin
          div_dvd <= {1'b0, prod_x};
          div_dvs <= den;
          state <= S_Q_DX;
        end
        S_Q_DX: begin
          if (div_done) begin
            r_px <= neg_x ? (hit.start_x - div_q[31:0]) : (hit.start_x + div_q[31:0]);
            div_dvd <= {1'b0, prod_y};
            state <= S_Q_DY;
          end
        end
        S_Q_DY: begin
          if (div_done) begin
            r_py <= neg_y ? (hit.start_y - div_q[31:0]) : (hit.start_y + div_q[31:0]);
            r_laser <= 1'b1;
            state <= S_OUT;
          end
        end
        S_OUT: begin
          if (!out_valid || out_ready) begin
            out_valid <= 1'b1;
            laser_on <= r_laser;
            speed_valid <= r_spdv;
            pos_x <= r_px;
            pos_y <= r_py;
            speed_out <= r_spd;
            status <= r_status;
            state <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

endmodule
